### design/ccdpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccdpu_pkg
// Shared types, constants and helpers of the CCD pixel unpacker.
// ----------------------------------------------------------------------------
package ccdpu_pkg;

    localparam int HALF_COLS = 1500;
    localparam int HALF_ROWS = 1000;

    localparam int COL_W   = 11;
    localparam int ROW_W   = 10;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [12:0] HALF_COLS_W = 13'(HALF_COLS);
    localparam logic [12:0] HALF_ROWS_W = 13'(HALF_ROWS);

    localparam logic [COL_W-1:0] COL_COUNT_RST = COL_W'(1500);
    localparam logic [ROW_W-1:0] ROW_COUNT_RST = ROW_W'(1000);

    typedef enum logic [2:0] {
        REG_BINNED    = 3'd0,
        REG_COL_START = 3'd1,
        REG_COL_COUNT = 3'd2,
        REG_ROW_START = 3'd3,
        REG_ROW_COUNT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic             binned;
        logic [COL_W-1:0] col_start;
        logic [ROW_W-1:0] row_start;
        logic [COL_W-1:0] ncols;
        logic [ROW_W-1:0] nrows;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0] cbase;
        logic [ROW_W-1:0] rbase;
        logic [15:0]      value;
        logic [1:0]       first;
        logic [1:0]       last;
        logic             win_end;
    } t_job;

    // window count clipped to the sensor edge
    function automatic logic [12:0] clip_cnt(input logic [12:0] start,
                                             input logic [12:0] cnt,
                                             input logic [12:0] limit);
        logic [12:0] room;
        room = limit - start;
        if (start >= limit) begin
            clip_cnt = '0;
        end else if (cnt > room) begin
            clip_cnt = room;
        end else begin
            clip_cnt = cnt;
        end
    endfunction

endpackage
`default_nettype wire

### design/ccdpu_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccdpu_cfg
// Register file on the APB-style port; keeps the clipped window counts.
// ----------------------------------------------------------------------------
module ccdpu_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ccdpu_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ccdpu_pkg::DATA_W-1:0] pwdata,
    output logic      [ccdpu_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output ccdpu_pkg::t_cfg                 o_cfg
);
    import ccdpu_pkg::*;

    logic             r_binned;
    logic [COL_W-1:0] r_col_start, r_col_count, r_ncols;
    logic [ROW_W-1:0] r_row_start, r_row_count, r_nrows;

    logic             n_binned;
    logic [COL_W-1:0] n_col_start, n_col_count;
    logic [ROW_W-1:0] n_row_start, n_row_count;
    logic [12:0]      cols_clip, rows_clip;
    logic             wr;
    t_reg_idx         idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = t_reg_idx'(paddr[4:2]);

    always_comb begin
        n_binned    = r_binned;
        n_col_start = r_col_start;
        n_col_count = r_col_count;
        n_row_start = r_row_start;
        n_row_count = r_row_count;
        if (wr) begin
            unique case (idx)
                REG_BINNED:    n_binned    = pwdata[0];
                REG_COL_START: n_col_start = pwdata[COL_W-1:0];
                REG_COL_COUNT: n_col_count = pwdata[COL_W-1:0];
                REG_ROW_START: n_row_start = pwdata[ROW_W-1:0];
                REG_ROW_COUNT: n_row_count = pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
        cols_clip = clip_cnt(13'(n_col_start), 13'(n_col_count), HALF_COLS_W);
        rows_clip = clip_cnt(13'(n_row_start), 13'(n_row_count), HALF_ROWS_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binned    <= 1'b0;
            r_col_start <= '0;
            r_col_count <= COL_COUNT_RST;
            r_row_start <= '0;
            r_row_count <= ROW_COUNT_RST;
            r_ncols     <= COL_COUNT_RST;
            r_nrows     <= ROW_COUNT_RST;
        end else begin
            r_binned    <= n_binned;
            r_col_start <= n_col_start;
            r_col_count <= n_col_count;
            r_row_start <= n_row_start;
            r_row_count <= n_row_count;
            r_ncols     <= cols_clip[COL_W-1:0];
            r_nrows     <= rows_clip[ROW_W-1:0];
        end
    end

    always_comb begin
        unique case (idx)
            REG_BINNED:    prdata = DATA_W'(r_binned);
            REG_COL_START: prdata = DATA_W'(r_col_start);
            REG_COL_COUNT: prdata = DATA_W'(r_col_count);
            REG_ROW_START: prdata = DATA_W'(r_row_start);
            REG_ROW_COUNT: prdata = DATA_W'(r_row_count);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = '{binned:    r_binned,
                     col_start: r_col_start,
                     row_start: r_row_start,
                     ncols:     r_ncols,
                     nrows:     r_nrows};

endmodule
`default_nettype wire

### design/ccdpu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccdpu_core
// Byte pairing and window walk; hands one cell job per completed sample.
// ----------------------------------------------------------------------------
module ccdpu_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ccdpu_pkg::t_cfg i_cfg,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_frame_start,
    output logic                 o_job_load,
    output ccdpu_pkg::t_job      o_job
);
    import ccdpu_pkg::*;

    logic [7:0]       r_hold;
    logic             r_bphase;
    logic [1:0]       r_sphase;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_wdone;

    logic [7:0]       n_hold;
    logic             n_bphase;
    logic [1:0]       n_sphase;
    logic [COL_W-1:0] n_col, col_inc;
    logic [ROW_W-1:0] n_row;
    logic             n_wdone;
    logic             emit, cell_end, win_end, stop;
    logic [1:0]       first, last;

    always_comb begin
        n_hold   = r_hold;
        n_bphase = r_bphase;
        n_sphase = r_sphase;
        n_col    = r_col;
        n_row    = r_row;
        n_wdone  = r_wdone;
        emit     = 1'b0;
        cell_end = 1'b0;
        win_end  = 1'b0;
        stop     = 1'b0;
        first    = '0;
        last     = '0;
        col_inc  = '0;
        if (i_frame_start) begin
            n_hold   = '0;
            n_bphase = 1'b0;
            n_sphase = '0;
            n_col    = '0;
            n_row    = '0;
            n_wdone  = 1'b0;
        end
        if (!n_wdone) begin
            if (i_cfg.ncols == '0 || i_cfg.nrows == '0 || n_row >= i_cfg.nrows) begin
                n_wdone = 1'b1;
                stop    = 1'b1;
            end else if (n_col >= i_cfg.ncols) begin
                n_col = '0;
                n_row = n_row + ROW_W'(1);
                if (n_row >= i_cfg.nrows) begin
                    n_wdone = 1'b1;
                    stop    = 1'b1;
                end
            end
            if (!stop) begin
                if (!n_bphase) begin
                    n_hold   = i_data_byte;
                    n_bphase = 1'b1;
                end else begin
                    n_bphase = 1'b0;
                    emit     = 1'b1;
                    if (i_cfg.binned) begin
                        first    = 2'd0;
                        last     = 2'd3;
                        cell_end = 1'b1;
                        n_sphase = 2'd0;
                    end else begin
                        first    = n_sphase;
                        last     = n_sphase;
                        cell_end = (n_sphase == 2'd3);
                        n_sphase = n_sphase + 2'd1;
                    end
                end
            end
        end
        o_job.cbase   = i_cfg.col_start + n_col;
        o_job.rbase   = i_cfg.row_start + n_row;
        o_job.value   = {i_data_byte, n_hold};
        o_job.first   = first;
        o_job.last    = last;
        if (cell_end) begin
            col_inc = n_col + COL_W'(1);
            if (col_inc >= i_cfg.ncols) begin
                n_col = '0;
                n_row = n_row + ROW_W'(1);
                if (n_row >= i_cfg.nrows) begin
                    n_wdone = 1'b1;
                    win_end = 1'b1;
                end
            end else begin
                n_col = col_inc;
            end
        end
        o_job.win_end = win_end;
    end

    assign o_job_load = i_accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= '0;
            r_bphase <= 1'b0;
            r_sphase <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_wdone  <= 1'b0;
        end else if (i_accept) begin
            r_hold   <= n_hold;
            r_bphase <= n_bphase;
            r_sphase <= n_sphase;
            r_col    <= n_col;
            r_row    <= n_row;
            r_wdone  <= n_wdone;
        end
    end

endmodule
`default_nettype wire

### design/ccdpu_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccdpu_emit
// Cell job register and output word register; one write per unstalled cycle.
// ----------------------------------------------------------------------------
module ccdpu_emit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_job_load,
    input  wire ccdpu_pkg::t_job i_job,
    output logic                 o_job_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [11:0]          o_pixel_col,
    output logic [10:0]          o_pixel_row,
    output logic [15:0]          o_pixel_value,
    output logic                 o_run_last,
    output logic                 o_frame_done
);
    import ccdpu_pkg::*;

    t_job       r_job;
    logic       r_job_v;
    logic [1:0] r_k;
    logic       take, job_done, out_free, at_last;

    assign out_free    = !o_out_valid || !i_out_stall;
    assign take        = r_job_v && out_free;
    assign at_last     = (r_k == r_job.last);
    assign job_done    = take && at_last;
    assign o_job_ready = !r_job_v || job_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_job_v     <= i_job_load || (r_job_v && !job_done);
            o_out_valid <= take || (o_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_load) begin
            r_job <= i_job;
            r_k   <= i_job.first;
        end else if (take && !at_last) begin
            r_k   <= r_k + 2'd1;
        end
        if (take) begin
            o_pixel_col   <= {r_job.cbase, r_k[1]};
            o_pixel_row   <= {r_job.rbase, r_k[1] ^ r_k[0]};
            o_pixel_value <= r_job.value;
            o_run_last    <= at_last;
            o_frame_done  <= at_last && r_job.win_end;
        end
    end

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_run_last)
        else $error("frame_done without run_last");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_v |-> r_k <= r_job.last)
        else $error("cell index beyond last");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_load |-> (!r_job_v || job_done))
        else $error("job loaded over a pending job");

    a_job_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !at_last |=> r_job_v)
        else $error("job dropped before last write");

endmodule
`default_nettype wire

### design/ccd_pixel_unpack_to_frame.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_pixel_unpack_to_frame
// Pairs ADC bytes into 16-bit samples and issues frame-store writes.
// ----------------------------------------------------------------------------
// The high byte of a sample loads the cell job register; its first write is
// then registered in the output word register. Throughput: one byte per
// unstalled input cycle; one write per unstalled output cycle. A binned sample
// gives four writes; input is stalled while a cell job has writes pending.
// Reset (synchronous, active low) clears counters and valids and loads the
// register defaults: full mode, window 0..1499 by 0..999.
module ccd_pixel_unpack_to_frame (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_frame_start,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [11:0]                       o_pixel_col,
    output logic [10:0]                       o_pixel_row,
    output logic [15:0]                       o_pixel_value,
    output logic                              o_run_last,
    output logic                              o_frame_done,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ccdpu_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ccdpu_pkg::DATA_W-1:0] pwdata,
    output logic      [ccdpu_pkg::DATA_W-1:0] prdata,
    output logic                              pready
);
    import ccdpu_pkg::*;

    t_cfg cfg;
    t_job job;
    logic job_load, job_ready, accept;

    assign o_in_stall = !job_ready;
    assign accept     = i_in_valid && !o_in_stall;

    ccdpu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ccdpu_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_job_load    (job_load),
        .o_job         (job)
    );

    ccdpu_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_load    (job_load),
        .i_job         (job),
        .o_job_ready   (job_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_col   (o_pixel_col),
        .o_pixel_row   (o_pixel_row),
        .o_pixel_value (o_pixel_value),
        .o_run_last    (o_run_last),
        .o_frame_done  (o_frame_done)
    );

endmodule
`default_nettype wire
